/* hw/rtl/vwp_pkg.sv */
package vwp_pkg;

    typedef logic signed [31:0] t_q;
    typedef t_q [3:0]  t_vec4;
    typedef t_q [2:0]  t_vec3;
    typedef t_q [15:0] t_mat;

    localparam logic [1:0] CFG_ORG_X  = 2'd0;
    localparam logic [1:0] CFG_ORG_Y  = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT = 2'd3;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_PROJ = 1'b1;
    localparam logic SEL_MODEL = 1'b0;
    localparam logic SEL_PROJ  = 1'b1;

    localparam t_q Q_MAX = 32'sh7fffffff;
    localparam t_q Q_MIN = 32'sh80000000;

    function automatic t_q sat_q(input logic signed [71:0] v);
        t_q r;
        if (v > 72'sd2147483647) begin
            r = Q_MAX;
        end else if (v < -72'sd2147483648) begin
            r = Q_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* hw/rtl/vwp_mat_vec.sv */
module vwp_mat_vec #(
    parameter int FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  vwp_pkg::t_mat i_mat,
    input  vwp_pkg::t_vec4 i_vec,
    output vwp_pkg::t_vec4 o_vec
);
    import vwp_pkg::*;

    logic signed [63:0] r_prod [16];
    t_vec4              r_vec;
    t_vec4              n_vec;

    // stage 1: sixteen exact products, row r column c
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    r_prod[r*4+c] <= $signed(i_mat[c*4+r]) * $signed(i_vec[c]);
                end
            end
        end
    end

    // stage 2: row sums, floor by FRAC_BITS, saturate
    always_comb begin
        logic signed [65:0] s;
        for (int r = 0; r < 4; r++) begin
            s = 66'(r_prod[r*4]) + 66'(r_prod[r*4+1])
              + 66'(r_prod[r*4+2]) + 66'(r_prod[r*4+3]);
            n_vec[r] = sat_q(72'(s >>> FRAC_BITS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule

/* hw/rtl/vwp_div.sv */
module vwp_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  vwp_pkg::t_vec4 i_clip,
    output vwp_pkg::t_vec3 o_ndc,
    output logic           o_ok
);
    import vwp_pkg::*;

    localparam int QW = 32 + FRAC_BITS;

    logic [31:0]   r_rem [0:QW][3];
    logic [QW-1:0] r_num [0:QW][3];
    logic [31:0]   r_den [0:QW];
    logic [2:0]    r_neg [0:QW];
    logic          r_ok  [0:QW];
    logic [31:0]   n_rem [0:QW-1][3];
    logic [QW-1:0] n_num [0:QW-1][3];
    t_vec3         n_ndc;
    t_vec3         r_ndc;
    logic          r_ok_out;

    // one restoring quotient bit per stage
    always_comb begin
        logic [32:0] t;
        logic        ge;
        for (int s = 0; s < QW; s++) begin
            for (int k = 0; k < 3; k++) begin
                t  = {r_rem[s][k], r_num[s][k][QW-1]};
                ge = (t >= {1'b0, r_den[s]});
                n_rem[s][k] = ge ? 32'(t - {1'b0, r_den[s]}) : t[31:0];
                n_num[s][k] = {r_num[s][k][QW-2:0], ge};
            end
        end
    end

    // stage 0: magnitudes, signs, zero w check; then the quotient stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_clip[3][31] ? 32'(-i_clip[3]) : 32'(i_clip[3]);
            r_ok[0]  <= (i_clip[3] != 32'sd0);
            for (int k = 0; k < 3; k++) begin
                r_neg[0][k] <= i_clip[k][31] ^ i_clip[3][31];
                r_rem[0][k] <= '0;
                r_num[0][k] <= QW'(i_clip[k][31] ? 32'(-i_clip[k]) : 32'(i_clip[k]))
                               << FRAC_BITS;
            end
            for (int s = 0; s < QW; s++) begin
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
                r_ok[s+1]  <= r_ok[s];
                for (int k = 0; k < 3; k++) begin
                    r_rem[s+1][k] <= n_rem[s][k];
                    r_num[s+1][k] <= n_num[s][k];
                end
            end
        end
    end

    // sign and saturate
    always_comb begin
        logic signed [71:0] v;
        for (int k = 0; k < 3; k++) begin
            v = 72'($signed({1'b0, r_num[QW][k]}));
            if (r_neg[QW][k]) begin
                v = -v;
            end
            n_ndc[k] = sat_q(v);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ndc    <= n_ndc;
            r_ok_out <= r_ok[QW];
        end
    end

    assign o_ndc = r_ndc;
    assign o_ok  = r_ok_out;

endmodule

/* hw/rtl/vwp_view.sv */
module vwp_view #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  vwp_pkg::t_vec3     i_ndc,
    input  logic               i_ok,
    input  logic signed [15:0] i_org_x,
    input  logic signed [15:0] i_org_y,
    input  logic [15:0]        i_width,
    input  logic [15:0]        i_height,
    output vwp_pkg::t_vec3     o_win,
    output logic               o_ok
);
    import vwp_pkg::*;

    localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;

    logic signed [50:0] r_px;
    logic signed [50:0] r_py;
    logic signed [33:0] r_pz;
    logic               r_ok1;
    t_vec3              r_win;
    logic               r_ok2;
    t_vec3              n_win;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px  <= (34'(i_ndc[0]) + ONE) * $signed({1'b0, i_width});
            r_py  <= (34'(i_ndc[1]) + ONE) * $signed({1'b0, i_height});
            r_pz  <= 34'(i_ndc[2]) + ONE;
            r_ok1 <= i_ok;
        end
    end

    always_comb begin
        n_win[0] = sat_q((72'(i_org_x) <<< FRAC_BITS) + 72'(r_px >>> 1));
        n_win[1] = sat_q((72'(i_org_y) <<< FRAC_BITS) + 72'(r_py >>> 1));
        n_win[2] = sat_q(72'(r_pz >>> 1));
        if (!r_ok1) begin
            n_win = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_win <= n_win;
            r_ok2 <= r_ok1;
        end
    end

    assign o_win = r_win;
    assign o_ok  = r_ok2;

endmodule

/* hw/rtl/vertex_window_projection.sv */
// channel  dir  fields (low bit up)
// s_axis   in   tdata: entry_index, entry_value, obj_x, obj_y, obj_z; tuser: kind, matrix_select
// m_axis   out  tdata: win_x, win_y, win_z; tuser: ok
// cfg      in   write enable, index 0..3, 16-bit data
// One request per cycle while the pipeline is not stalled; a point's result passes both transforms,
// the one-bit-per-stage divider (32 + FRAC_BITS stages), the viewport map and the output register.
// Load requests give no result.
// Reset clears both matrices and sets the viewport to its defaults.
// A stall freezes the whole pipeline only when its last stage holds a result.
module vertex_window_projection #(
    parameter int FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [135:0] i_s_axis_tdata,  // entry_index, entry_value, obj_x, obj_y, obj_z
    input  logic [1:0]   i_s_axis_tuser,  // kind, matrix_select
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [95:0]  o_m_axis_tdata,  // win_x, win_y, win_z
    output logic [0:0]   o_m_axis_tuser,  // ok
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);
    import vwp_pkg::*;

    localparam int LAT = 40 + FRAC_BITS;
    localparam t_q ONE = 32'sd1 <<< FRAC_BITS;

    logic               in_kind;
    logic               in_sel;
    logic [3:0]         in_idx;
    t_q                 in_val;
    t_vec4              in_pt;
    logic               en;
    logic               acc;

    t_mat               r_model;
    t_mat               r_proj;
    logic [LAT-1:0]     r_vld;
    logic [1:0]         r_ld_v;
    logic [3:0]         r_ld_idx [2];
    t_q                 r_ld_val [2];
    logic signed [15:0] r_org_x;
    logic signed [15:0] r_org_y;
    logic [15:0]        r_width;
    logic [15:0]        r_height;
    logic               r_out_valid;
    t_vec3              r_out_win;
    logic               r_out_ok;

    t_vec4              eye;
    t_vec4              clip;
    t_vec3              ndc;
    logic               ndc_ok;
    t_vec3              win;
    logic               win_ok;

    assign in_kind  = i_s_axis_tuser[0];
    assign in_sel   = i_s_axis_tuser[1];
    assign in_idx   = i_s_axis_tdata[3:0];
    assign in_val   = i_s_axis_tdata[35:4];
    assign in_pt[0] = i_s_axis_tdata[67:36];
    assign in_pt[1] = i_s_axis_tdata[99:68];
    assign in_pt[2] = i_s_axis_tdata[131:100];
    assign in_pt[3] = ONE;

    assign en  = !r_vld[LAT-1] || !r_out_valid || i_m_axis_tready;
    assign acc = i_s_axis_tvalid && en;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model <= '0;
            r_proj  <= '0;
            r_vld   <= '0;
            r_ld_v  <= '0;
        end else begin
            if (acc && in_kind == KIND_LOAD && in_sel == SEL_MODEL) begin
                r_model[in_idx] <= in_val;
            end
            if (en) begin
                r_vld  <= {r_vld[LAT-2:0], acc && in_kind == KIND_PROJ};
                r_ld_v <= {r_ld_v[0], acc && in_kind == KIND_LOAD && in_sel == SEL_PROJ};
                // projection matrix updates in step with the second transform
                if (r_ld_v[1]) begin
                    r_proj[r_ld_idx[1]] <= r_ld_val[1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ld_idx[0] <= in_idx;
            r_ld_val[0] <= in_val;
            r_ld_idx[1] <= r_ld_idx[0];
            r_ld_val[1] <= r_ld_val[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_width  <= 16'd1024;
            r_height <= 16'd768;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORG_X:  r_org_x  <= i_cfg_data;
                CFG_ORG_Y:  r_org_y  <= i_cfg_data;
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vwp_mat_vec #(.FRAC_BITS(FRAC_BITS)) u_eye (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mat (r_model),
        .i_vec (in_pt),
        .o_vec (eye)
    );

    vwp_mat_vec #(.FRAC_BITS(FRAC_BITS)) u_clip (
        .i_clk (i_clk),
        .i_en  (en),
        .i_mat (r_proj),
        .i_vec (eye),
        .o_vec (clip)
    );

    vwp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_clip (clip),
        .o_ndc  (ndc),
        .o_ok   (ndc_ok)
    );

    vwp_view #(.FRAC_BITS(FRAC_BITS)) u_view (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_ndc    (ndc),
        .i_ok     (ndc_ok),
        .i_org_x  (r_org_x),
        .i_org_y  (r_org_y),
        .i_width  (r_width),
        .i_height (r_height),
        .o_win    (win),
        .o_ok     (win_ok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_m_axis_tready) begin
            r_out_valid <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_axis_tready) begin
            r_out_win <= win;
            r_out_ok  <= win_ok;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_win[2], r_out_win[1], r_out_win[0]};
    assign o_m_axis_tuser  = r_out_ok;

endmodule
